[src/positional_insert_remove_list_unit_defines.svh]
// Assertion macros for the positional insert/remove list unit.
// No dependencies; included by the checker module.
`ifndef POSITIONAL_INSERT_REMOVE_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_UNIT_DEFINES_SVH

// same-cycle implication
`define PIRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pirl check failed (same cycle)");

// next-cycle implication
`define PIRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pirl check failed (next cycle)");

`endif

[src/pirl_pkg.sv]
// Package for the positional insert/remove list unit: payload types, codes,
// controller command/status structs. No dependencies.
`timescale 1ns / 1ps

package pirl_pkg;

    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 8;
    localparam int POS_W         = 7;
    localparam int CAP_W         = 8;
    localparam int DEPTH_DEF     = 128;
    localparam int WORD_BITS_DEF = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef struct packed {
        t_func                    func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [COUNT_W-1:0]       count;
        logic [1:0]               status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_REM_DATA,
        S_REM_RD,
        S_REM_WR,
        S_RD_WAIT,
        S_CLR,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_LOAD_CNT,
        IDX_LOAD_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RADDR_POS,
        RADDR_IDX_M1,
        RADDR_IDX_P1
    } t_raddr_sel;

    typedef enum logic {
        WADDR_IDX,
        WADDR_POS
    } t_waddr_sel;

    typedef enum logic [1:0] {
        WDATA_ZERO,
        WDATA_RDATA,
        WDATA_VALUE
    } t_wdata_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ZERO
    } t_cnt_op;

    typedef struct packed {
        logic       load_item;
        t_idx_op    idx_op;
        logic       ram_re;
        t_raddr_sel raddr_sel;
        logic       ram_we;
        t_waddr_sel waddr_sel;
        t_wdata_sel wdata_sel;
        t_cnt_op    cnt_op;
        logic       res_load;
        logic       res_rdata;
        t_status    res_status;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  ins_bad;
        logic  ins_full;
        logic  rem_bad;
        logic  rd_bad;
        logic  idx_gt_pos;
        logic  idx_p1_lt_cnt;
        logic  idx_lt_cnt;
        logic  idx_last;
    } t_flags;

endpackage

[src/pirl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pirl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/pirl_dp.sv]
// Datapath of the list unit: entry RAM, length, index counter, item and
// result registers, limit register. Depends on pirl_pkg and pirl_ram.
`timescale 1ns / 1ps

module pirl_dp #(
    parameter int DEPTH     = pirl_pkg::DEPTH_DEF,
    parameter int WORD_BITS = pirl_pkg::WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pirl_pkg::t_in_item           i_in_data,
    input  logic                         i_cfg_we,
    input  logic [pirl_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  pirl_pkg::t_cmd               i_cmd,
    output pirl_pkg::t_flags             o_flags,
    output pirl_pkg::t_out_item          o_out_data
);

    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = AW + 1;
    localparam int CW     = (IW > pirl_pkg::COUNT_W) ? IW : pirl_pkg::COUNT_W;
    localparam int LIM_MAX = (DEPTH > 255) ? 255 : DEPTH;
    localparam logic [pirl_pkg::CAP_W-1:0] LIM_MAX_C = pirl_pkg::CAP_W'(LIM_MAX);

    pirl_pkg::t_in_item                 r_item;
    logic [pirl_pkg::COUNT_W-1:0]       r_cnt, n_cnt;
    logic [IW-1:0]                      r_idx, n_idx;
    logic [pirl_pkg::CAP_W-1:0]         r_cap;
    logic signed [pirl_pkg::DATA_W-1:0] r_res_data;
    pirl_pkg::t_status                  r_res_status;

    logic [pirl_pkg::CAP_W-1:0] lim;
    logic [CW-1:0]              idx_w, cnt_w, pos_w;
    logic [IW-1:0]              idx_m1, idx_p1;
    logic [AW-1:0]              pos_a, raddr, waddr;
    logic [WORD_BITS-1:0]       wdata, rdata;
    logic signed [pirl_pkg::DATA_W-1:0] rdata_ext;

    assign lim   = (r_cap > LIM_MAX_C) ? LIM_MAX_C : r_cap;
    assign idx_w = CW'(r_idx);
    assign cnt_w = CW'(r_cnt);
    assign pos_w = CW'(r_item.position);
    assign idx_m1 = r_idx - IW'(1);
    assign idx_p1 = r_idx + IW'(1);
    assign pos_a  = AW'(r_item.position);
    assign rdata_ext = pirl_pkg::DATA_W'(signed'(rdata));

    always_comb begin
        o_flags.func          = r_item.func;
        o_flags.ins_bad       = pos_w > cnt_w;
        o_flags.ins_full      = r_cnt >= lim;
        o_flags.rem_bad       = pos_w >= cnt_w;
        o_flags.rd_bad        = pos_w >= CW'(DEPTH);
        o_flags.idx_gt_pos    = idx_w > pos_w;
        o_flags.idx_p1_lt_cnt = (idx_w + CW'(1)) < cnt_w;
        o_flags.idx_lt_cnt    = idx_w < cnt_w;
        o_flags.idx_last      = r_idx == IW'(DEPTH - 1);
    end

    always_comb begin
        case (i_cmd.raddr_sel)
            pirl_pkg::RADDR_IDX_M1: raddr = idx_m1[AW-1:0];
            pirl_pkg::RADDR_IDX_P1: raddr = idx_p1[AW-1:0];
            default:                raddr = pos_a;
        endcase
        waddr = (i_cmd.waddr_sel == pirl_pkg::WADDR_POS) ? pos_a : r_idx[AW-1:0];
        case (i_cmd.wdata_sel)
            pirl_pkg::WDATA_RDATA: wdata = rdata;
            pirl_pkg::WDATA_VALUE: wdata = WORD_BITS'(r_item.value);
            default:               wdata = '0;
        endcase
    end

    pirl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (i_cmd.idx_op)
            pirl_pkg::IDX_ZERO:     n_idx = '0;
            pirl_pkg::IDX_LOAD_CNT: n_idx = IW'(r_cnt);
            pirl_pkg::IDX_LOAD_POS: n_idx = IW'(r_item.position);
            pirl_pkg::IDX_INC:      n_idx = idx_p1;
            pirl_pkg::IDX_DEC:      n_idx = idx_m1;
            default:                n_idx = r_idx;
        endcase
        case (i_cmd.cnt_op)
            pirl_pkg::CNT_INC:  n_cnt = r_cnt + pirl_pkg::COUNT_W'(1);
            pirl_pkg::CNT_DEC:  n_cnt = r_cnt - pirl_pkg::COUNT_W'(1);
            pirl_pkg::CNT_ZERO: n_cnt = '0;
            default:            n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
            r_cap <= pirl_pkg::CAP_RESET;
        end else begin
            r_idx <= n_idx;
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.res_load) begin
            r_res_data   <= i_cmd.res_rdata ? rdata_ext : '0;
            r_res_status <= i_cmd.res_status;
        end
    end

    always_comb begin
        o_out_data.data_out = r_res_data;
        o_out_data.count    = r_cnt;
        o_out_data.status   = r_res_status;
    end

endmodule

[src/pirl_ctrl.sv]
// Controller of the list unit: sequences init sweep, shifts, clear and the
// handshakes. Depends on pirl_pkg.
`timescale 1ns / 1ps

module pirl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pirl_pkg::t_flags i_flags,
    output pirl_pkg::t_cmd   o_cmd
);

    pirl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pirl_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_out_valid       = 1'b0;
        o_cmd.load_item   = 1'b0;
        o_cmd.idx_op      = pirl_pkg::IDX_HOLD;
        o_cmd.ram_re      = 1'b0;
        o_cmd.raddr_sel   = pirl_pkg::RADDR_POS;
        o_cmd.ram_we      = 1'b0;
        o_cmd.waddr_sel   = pirl_pkg::WADDR_IDX;
        o_cmd.wdata_sel   = pirl_pkg::WDATA_ZERO;
        o_cmd.cnt_op      = pirl_pkg::CNT_HOLD;
        o_cmd.res_load    = 1'b0;
        o_cmd.res_rdata   = 1'b0;
        o_cmd.res_status  = pirl_pkg::ST_OK;

        case (r_state)
            pirl_pkg::S_INIT: begin
                o_cmd.ram_we = 1'b1;
                if (i_flags.idx_last) begin
                    o_cmd.idx_op = pirl_pkg::IDX_ZERO;
                    n_state      = pirl_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_op = pirl_pkg::IDX_INC;
                end
            end
            pirl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = pirl_pkg::S_DECODE;
                end
            end
            pirl_pkg::S_DECODE: begin
                case (i_flags.func)
                    pirl_pkg::FUNC_INSERT: begin
                        if (i_flags.ins_bad || i_flags.ins_full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = i_flags.ins_bad ? pirl_pkg::ST_BADPOS
                                                               : pirl_pkg::ST_FULL;
                            n_state          = pirl_pkg::S_RESP;
                        end else begin
                            o_cmd.idx_op = pirl_pkg::IDX_LOAD_CNT;
                            n_state      = pirl_pkg::S_INS_RD;
                        end
                    end
                    pirl_pkg::FUNC_REMOVE: begin
                        if (i_flags.rem_bad) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = pirl_pkg::ST_BADPOS;
                            n_state          = pirl_pkg::S_RESP;
                        end else begin
                            o_cmd.ram_re = 1'b1;
                            o_cmd.idx_op = pirl_pkg::IDX_LOAD_POS;
                            n_state      = pirl_pkg::S_REM_DATA;
                        end
                    end
                    pirl_pkg::FUNC_READ: begin
                        if (i_flags.rd_bad) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = pirl_pkg::ST_BADPOS;
                            n_state          = pirl_pkg::S_RESP;
                        end else begin
                            o_cmd.ram_re = 1'b1;
                            n_state      = pirl_pkg::S_RD_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.idx_op = pirl_pkg::IDX_ZERO;
                        n_state      = pirl_pkg::S_CLR;
                    end
                endcase
            end
            pirl_pkg::S_INS_RD: begin
                if (i_flags.idx_gt_pos) begin
                    o_cmd.ram_re    = 1'b1;
                    o_cmd.raddr_sel = pirl_pkg::RADDR_IDX_M1;
                    n_state         = pirl_pkg::S_INS_WR;
                end else begin
                    o_cmd.ram_we    = 1'b1;
                    o_cmd.waddr_sel = pirl_pkg::WADDR_POS;
                    o_cmd.wdata_sel = pirl_pkg::WDATA_VALUE;
                    o_cmd.cnt_op    = pirl_pkg::CNT_INC;
                    o_cmd.res_load  = 1'b1;
                    n_state         = pirl_pkg::S_RESP;
                end
            end
            pirl_pkg::S_INS_WR: begin
                o_cmd.ram_we    = 1'b1;
                o_cmd.wdata_sel = pirl_pkg::WDATA_RDATA;
                o_cmd.idx_op    = pirl_pkg::IDX_DEC;
                n_state         = pirl_pkg::S_INS_RD;
            end
            pirl_pkg::S_REM_DATA: begin
                o_cmd.res_load  = 1'b1;
                o_cmd.res_rdata = 1'b1;
                n_state         = pirl_pkg::S_REM_RD;
            end
            pirl_pkg::S_REM_RD: begin
                if (i_flags.idx_p1_lt_cnt) begin
                    o_cmd.ram_re    = 1'b1;
                    o_cmd.raddr_sel = pirl_pkg::RADDR_IDX_P1;
                    n_state         = pirl_pkg::S_REM_WR;
                end else begin
                    o_cmd.cnt_op = pirl_pkg::CNT_DEC;
                    n_state      = pirl_pkg::S_RESP;
                end
            end
            pirl_pkg::S_REM_WR: begin
                o_cmd.ram_we    = 1'b1;
                o_cmd.wdata_sel = pirl_pkg::WDATA_RDATA;
                o_cmd.idx_op    = pirl_pkg::IDX_INC;
                n_state         = pirl_pkg::S_REM_RD;
            end
            pirl_pkg::S_RD_WAIT: begin
                o_cmd.res_load  = 1'b1;
                o_cmd.res_rdata = 1'b1;
                n_state         = pirl_pkg::S_RESP;
            end
            pirl_pkg::S_CLR: begin
                if (i_flags.idx_lt_cnt) begin
                    o_cmd.ram_we = 1'b1;
                    o_cmd.idx_op = pirl_pkg::IDX_INC;
                end else begin
                    o_cmd.cnt_op   = pirl_pkg::CNT_ZERO;
                    o_cmd.res_load = 1'b1;
                    n_state        = pirl_pkg::S_RESP;
                end
            end
            pirl_pkg::S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = pirl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pirl_pkg::S_INIT;
            end
        endcase
    end

endmodule

[src/positional_insert_remove_list_unit.sv]
// Top level of the positional insert/remove list unit.
// Depends on pirl_pkg, pirl_ctrl, pirl_dp (and pirl_ram below it).
//
// Input channel (i_in_valid/o_in_ready, i_in_data): one operation per
// transfer - insert, remove, read or clear at a position. Output channel
// (o_out_valid/i_out_ready, o_out_data): one result per operation with the
// word, the list length after it and a status. i_cfg_we/i_cfg_wdata write
// the capacity limit. One operation is in flight at a time. Entries live in
// a RAM with one write and one registered read port, so each moved entry
// takes a read state and a write state. An insert moves the entries from
// the position to the end up by one, a remove moves those behind the
// position down by one, a clear zeroes the first n entries (n = length),
// and refused operations go straight to the result.
// o_in_ready is high again in the cycle right after the output transfer.
// Reset: length 0, limit 100, then a sweep zeroes all DEPTH RAM entries
// with o_in_ready low. A stalled receiver holds the result in its register
// and the unit takes no new input until it is taken.
`timescale 1ns / 1ps

module positional_insert_remove_list_unit #(
    parameter int DEPTH     = pirl_pkg::DEPTH_DEF,
    parameter int WORD_BITS = pirl_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  pirl_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pirl_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [pirl_pkg::CAP_W-1:0] i_cfg_wdata
);

    pirl_pkg::t_cmd   cmd;
    pirl_pkg::t_flags flags;

    pirl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    pirl_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .o_out_data  (o_out_data)
    );

endmodule

[src/pirl_chk.sv]
// Port-level checker for the list unit, bound to the top level.
// Depends on pirl_pkg and positional_insert_remove_list_unit_defines.svh.
`timescale 1ns / 1ps
`include "positional_insert_remove_list_unit_defines.svh"

module pirl_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pirl_pkg::t_out_item o_out_data
);

    logic res_err;

    assign res_err = o_out_valid && (o_out_data.status != pirl_pkg::ST_OK);

    // result holds until its transfer
    `PIRL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // one operation in flight: no input taken while a result waits
    `PIRL_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, o_in_ready, !o_out_valid)

    // after an input transfer the unit is busy
    `PIRL_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // refused operations carry no word
    `PIRL_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, res_err, o_out_data.data_out == '0)

endmodule

bind positional_insert_remove_list_unit pirl_chk u_pirl_chk (.*);
